[sv/srfm_pkg.sv]
// Package for the first-match replacement stream block.
// Holds the configuration record, register index codes and the burst control record.
package srfm_pkg;

    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_length;
        logic [DATA_W-1:0] replacement_bytes;
        logic [LEN_W-1:0]  replacement_length;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic fin;
        logic present;
    } burst_ctl_t;

endpackage

[sv/srfm_cfg_regs.sv]
// Configuration register file of the first-match replacement block.
// Depends on srfm_pkg for the register record and index codes.
module srfm_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [srfm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [srfm_pkg::DATA_W-1:0]           cfg_data,
    output srfm_pkg::cfg_t                        cfg
);

    srfm_pkg::cfg_t cfg_reg;
    srfm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (srfm_pkg::cfg_index_t'(cfg_index))
                srfm_pkg::CFG_PATTERN_BYTES:
                    cfg_next.pattern_bytes = cfg_data;
                srfm_pkg::CFG_PATTERN_LENGTH:
                    cfg_next.pattern_length = cfg_data[srfm_pkg::LEN_W-1:0];
                srfm_pkg::CFG_REPLACEMENT_BYTES:
                    cfg_next.replacement_bytes = cfg_data;
                srfm_pkg::CFG_REPLACEMENT_LENGTH:
                    cfg_next.replacement_length = cfg_data[srfm_pkg::LEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/srfm_window.sv]
// Input register, sliding match window and result list builder.
// Depends on srfm_pkg for the configuration and burst control records.
module srfm_window #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8,
    parameter int DEPTH       = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  srfm_pkg::cfg_t                     cfg,
    input  logic                               text_valid,
    output logic                               text_stall,
    input  logic [7:0]                         text_byte,
    input  logic                               final_byte,
    input  logic                               can_load,
    output srfm_pkg::burst_ctl_t               ctl,
    output logic [$clog2(DEPTH+1)-1:0]         desc_count,
    output logic [DEPTH-1:0][7:0]              desc_bytes,
    output logic [DEPTH-1:0]                   desc_made
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int REP_W  = $clog2(REPLACE_MAX + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                        iv_reg;
    logic                        iv_next;
    logic [7:0]                  ibyte_reg;
    logic                        ifin_reg;
    logic [PATTERN_MAX-1:0][7:0] win_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic                        rep_reg;
    logic                        rep_next;

    logic                        accept;
    logic                        advance;
    logic [FILL_W-1:0]           plen;
    logic [REP_W-1:0]            rlen;
    logic                        case_a;
    logic                        case_b;
    logic                        case_c;
    logic                        pop;
    logic [FILL_W-1:0]           fill1;
    logic [FILL_W-1:0]           fill2;
    logic [PATTERN_MAX-1:0][7:0] win1;
    logic                        pat_eq;
    logic                        match;
    logic                        flush;
    logic                        head;
    logic [7:0]                  head_byte;
    logic                        do_repl;
    logic [CNT_W-1:0]            h_cnt;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            w_cnt;
    logic [CNT_W-1:0]            t_cnt;
    logic [CNT_W-1:0]            sum_cnt;
    logic                        marker;

    assign plen = (cfg.pattern_length > srfm_pkg::LEN_W'(PATTERN_MAX))
                ? FILL_W'(PATTERN_MAX) : FILL_W'(cfg.pattern_length);
    assign rlen = (cfg.replacement_length > srfm_pkg::LEN_W'(REPLACE_MAX))
                ? REP_W'(REPLACE_MAX) : REP_W'(cfg.replacement_length);

    assign case_a = rep_reg;
    assign case_b = !rep_reg && (plen == '0) && (fill_reg == '0);
    assign case_c = !case_a && !case_b;

    assign pop   = case_c && (fill_reg >= plen) && (fill_reg != '0);
    assign fill1 = fill_reg - FILL_W'(pop);
    assign fill2 = fill1 + FILL_W'(1);

    always_comb
    begin
        win1 = win_reg;
        if (pop)
        begin
            for (int j = 0; j < PATTERN_MAX - 1; j++)
            begin
                win1[j] = win_reg[j + 1];
            end
        end
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (FILL_W'(j) == fill1)
            begin
                win1[j] = ibyte_reg;
            end
        end
    end

    always_comb
    begin
        pat_eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((FILL_W'(j) < plen) && (win1[j] != cfg.pattern_bytes[8*j +: 8]))
            begin
                pat_eq = 1'b0;
            end
        end
    end

    assign match     = case_c && (fill_reg <= plen) && (fill2 == plen) && pat_eq;
    assign flush     = case_c && ifin_reg && !match;
    assign head      = case_a || pop;
    assign head_byte = case_a ? ibyte_reg : win_reg[0];
    assign do_repl   = case_b || match;

    assign h_cnt   = CNT_W'(head);
    assign r_cnt   = do_repl ? CNT_W'(rlen) : '0;
    assign w_cnt   = flush ? CNT_W'(fill2) : '0;
    assign t_cnt   = CNT_W'(case_b);
    assign sum_cnt = h_cnt + r_cnt + w_cnt + t_cnt;
    assign marker  = ifin_reg && (sum_cnt == '0);

    // Lay out head byte, replacement, flushed window and trailing byte in order
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            desc_bytes[k] = ibyte_reg;
            desc_made[k]  = 1'b1;
            priority if (CNT_W'(k) < h_cnt)
            begin
                desc_bytes[k] = head_byte;
                desc_made[k]  = case_a;
            end
            else if (CNT_W'(k) < h_cnt + r_cnt)
            begin
                for (int j = 0; j < REPLACE_MAX; j++)
                begin
                    if (CNT_W'(k) == h_cnt + CNT_W'(j))
                    begin
                        desc_bytes[k] = cfg.replacement_bytes[8*j +: 8];
                    end
                end
            end
            else if (CNT_W'(k) < h_cnt + r_cnt + w_cnt)
            begin
                desc_made[k] = 1'b0;
                for (int j = 0; j < PATTERN_MAX; j++)
                begin
                    if (CNT_W'(k) == h_cnt + r_cnt + CNT_W'(j))
                    begin
                        desc_bytes[k] = win1[j];
                    end
                end
            end
            else
            begin
                desc_bytes[k] = ibyte_reg;
                desc_made[k]  = 1'b1;
            end
            if (marker)
            begin
                desc_bytes[k] = 8'h00;
                desc_made[k]  = rep_reg || match;
            end
        end
    end

    assign desc_count  = marker ? CNT_W'(1) : sum_cnt;
    assign advance     = iv_reg && (can_load || (desc_count == '0));
    assign ctl.load    = advance && (desc_count != '0);
    assign ctl.fin     = ifin_reg;
    assign ctl.present = !marker;

    assign text_stall = iv_reg && !advance;
    assign accept     = text_valid && !text_stall;
    assign iv_next    = accept || (iv_reg && !advance);

    always_comb
    begin
        fill_next = fill_reg;
        rep_next  = rep_reg;
        if (advance)
        begin
            if (case_b)
            begin
                rep_next = 1'b1;
            end
            if (case_c)
            begin
                fill_next = match ? '0 : fill2;
                rep_next  = match;
            end
            if (ifin_reg)
            begin
                fill_next = '0;
                rep_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg   <= 1'b0;
            fill_reg <= '0;
            rep_reg  <= 1'b0;
        end
        else
        begin
            iv_reg   <= iv_next;
            fill_reg <= fill_next;
            rep_reg  <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ibyte_reg <= text_byte;
            ifin_reg  <= final_byte;
        end
        if (advance && case_c)
        begin
            win_reg <= win1;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(PATTERN_MAX))
        else $error("window fill beyond pattern maximum");

    a_replaced_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg |-> (fill_reg == '0))
        else $error("window holds bytes after replacement");

    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ifin_reg) |=> ((fill_reg == '0) && !rep_reg))
        else $error("state not cleared after final transaction");
`endif

endmodule

[sv/srfm_burst.sv]
// Result buffer that hands out a list of result transactions one per cycle while result_stall is low.
// Depends on srfm_pkg for the burst control record.
module srfm_burst #(
    parameter int DEPTH = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  srfm_pkg::burst_ctl_t         ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   load_count,
    input  logic [DEPTH-1:0][7:0]        load_bytes,
    input  logic [DEPTH-1:0]             load_made,
    output logic                         can_load,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [7:0]                   out_byte,
    output logic                         byte_present,
    output logic                         run_last,
    output logic                         text_end,
    output logic                         match_made
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic                  fin_reg;
    logic                  present_reg;
    logic [DEPTH-1:0][7:0] byte_reg;
    logic [DEPTH-1:0]      made_reg;
    logic                  take;

    assign result_valid = (count_reg != '0);
    assign take         = result_valid && !result_stall;
    assign can_load     = !result_valid || (take && (count_reg == CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            fin_reg     <= 1'b0;
            present_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            count_reg   <= load_count;
            fin_reg     <= ctl.fin;
            present_reg <= ctl.present;
        end
        else if (take)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Advance the list by one entry per transaction taken
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            byte_reg <= load_bytes;
            made_reg <= load_made;
        end
        else if (take)
        begin
            byte_reg <= {8'h00, byte_reg[DEPTH-1:1]};
            made_reg <= {1'b0, made_reg[DEPTH-1:1]};
        end
    end

    assign out_byte     = present_reg ? byte_reg[0] : 8'h00;
    assign byte_present = present_reg;
    assign run_last     = (count_reg == CNT_W'(1));
    assign text_end     = fin_reg && (count_reg == CNT_W'(1));
    assign match_made   = made_reg[0];

endmodule

[sv/stream_replace_first_match.sv]
// A text transaction is held in the input register, then its results load into the result buffer.
// Throughput: one text byte per cycle while each byte yields at most one result and
// result_stall is low; a byte that yields n results (up to max(PATTERN_MAX, REPLACE_MAX) + 1)
// holds the result buffer until the single output port has drained the list.
// Reset clears the configuration, window fill, replacement flag and buffer count;
// window bytes are not cleared and no clearing pass runs.
module stream_replace_first_match #(
    parameter int PATTERN_MAX = 8,
    parameter int REPLACE_MAX = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [srfm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srfm_pkg::DATA_W-1:0]       cfg_data,
    input  logic                              text_valid,
    output logic                              text_stall,
    input  logic [7:0]                        text_byte,
    input  logic                              final_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [7:0]                        out_byte,
    output logic                              byte_present,
    output logic                              run_last,
    output logic                              text_end,
    output logic                              match_made
);

    localparam int DEPTH = ((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX) + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srfm_pkg::cfg_t        cfg;
    srfm_pkg::burst_ctl_t  ctl;
    logic [CNT_W-1:0]      desc_count;
    logic [DEPTH-1:0][7:0] desc_bytes;
    logic [DEPTH-1:0]      desc_made;
    logic                  can_load;

    srfm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srfm_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX),
        .DEPTH       (DEPTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .can_load   (can_load),
        .ctl        (ctl),
        .desc_count (desc_count),
        .desc_bytes (desc_bytes),
        .desc_made  (desc_made)
    );

    srfm_burst #(
        .DEPTH (DEPTH)
    ) u_burst (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .load_count   (desc_count),
        .load_bytes   (desc_bytes),
        .load_made    (desc_made),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .run_last     (run_last),
        .text_end     (text_end),
        .match_made   (match_made)
    );

endmodule
